FILE: rtl/fmc_pkg.sv
// Package of the floor move controller: item types, codes and defaults.
package fmc_pkg;

	localparam int FLOOR_BITS_DEF = 8;
	localparam int ROTATION_BITS_DEF = 16;
	localparam int RESQ_SLOTS = 4;
	localparam int QUEUE_PTR_BITS = $clog2(RESQ_SLOTS);
	localparam int QUEUE_CNT_BITS = $clog2(RESQ_SLOTS + 1);

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_MOTOR   = 2'd1,
		OP_TAG     = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OUTC_DONE   = 2'd0,
		OUTC_CANCEL = 2'd1,
		OUTC_ERROR  = 2'd2,
		OUTC_SPARE  = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		MODE_IDLE       = 3'd0,
		MODE_PROCESSING = 3'd1,
		MODE_MOVING     = 3'd2,
		MODE_ARRIVED    = 3'd3,
		MODE_STOPPED    = 3'd4,
		MODE_FAULT      = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		RS_PROCESSING  = 4'd0,
		RS_ALREADY     = 4'd1,
		RS_SUBMITTED   = 4'd2,
		RS_COMPLETED   = 4'd3,
		RS_TAG         = 4'd4,
		RS_INTERRUPTED = 4'd5,
		RS_MOTOR_ERROR = 4'd6,
		RS_REJECTED    = 4'd7,
		RS_NO_CHANGE   = 4'd8
	} reason_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  floor_value;
		outcome_t    motor_outcome;
		logic [7:0]  motor_error_code;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]  status_state;
		logic [3:0]  status_reason;
		logic [7:0]  floor_now;
		logic        move_valid;
		logic        move_direction;
		logic [23:0] move_rotations;
		logic        stop_request;
		logic [7:0]  fault_code;
		logic        last_result;
	} status_item_t;

	typedef struct packed {
		logic valid;
		logic two;
	} push_t;

endpackage

FILE: rtl/fmc_queue.sv
// Result queue that takes one or two items per cycle and hands out one while status_ready is high.
module fmc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fmc_pkg::push_t        push,
	input  fmc_pkg::status_item_t res0,
	input  fmc_pkg::status_item_t res1,
	output logic                  space_ok,
	output logic                  status_valid,
	input  logic                  status_ready,
	output fmc_pkg::status_item_t status
);

	fmc_pkg::status_item_t                 mem_q [fmc_pkg::RESQ_SLOTS];
	logic [fmc_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_q;
	logic [fmc_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_q;
	logic [fmc_pkg::QUEUE_CNT_BITS-1:0]    count_q;
	logic [fmc_pkg::QUEUE_PTR_BITS-1:0]    wr_next;
	logic [fmc_pkg::QUEUE_CNT_BITS-1:0]    push_n;
	logic                                  pop;

	assign pop = status_valid && status_ready;
	assign wr_next = wr_ptr_q + fmc_pkg::QUEUE_PTR_BITS'(1);
	assign push_n = !push.valid ? fmc_pkg::QUEUE_CNT_BITS'(0) :
		(push.two ? fmc_pkg::QUEUE_CNT_BITS'(2) : fmc_pkg::QUEUE_CNT_BITS'(1));
	assign space_ok = count_q <= fmc_pkg::QUEUE_CNT_BITS'(fmc_pkg::RESQ_SLOTS - 2);
	assign status_valid = count_q != '0;
	assign status = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= res0;
			if (push.two) begin
				mem_q[wr_next] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fmc_pkg::QUEUE_PTR_BITS'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fmc_pkg::QUEUE_PTR_BITS'(1);
			end
			count_q <= count_q + push_n - fmc_pkg::QUEUE_CNT_BITS'(pop);
		end
	end

endmodule

FILE: rtl/fmc_core.sv
// Input register, controller state and result computation.
module fmc_core #(
	parameter int FLOOR_BITS = fmc_pkg::FLOOR_BITS_DEF,
	parameter int ROTATION_BITS = fmc_pkg::ROTATION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  fmc_pkg::cmd_item_t    cmd,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  space_ok,
	output fmc_pkg::push_t        push,
	output fmc_pkg::status_item_t res0,
	output fmc_pkg::status_item_t res1
);

	localparam int FW = (FLOOR_BITS < 8) ? FLOOR_BITS : 8;
	localparam int RW = (ROTATION_BITS < 16) ? ROTATION_BITS : 16;

	fmc_pkg::cmd_item_t item_s1;
	logic               valid_s1;
	logic               advance;

	fmc_pkg::mode_t     mode_q;
	fmc_pkg::mode_t     mode_d;
	logic [FW-1:0]      floor_q;
	logic [FW-1:0]      floor_d;
	logic [FW-1:0]      goal_q;
	logic [FW-1:0]      goal_d;
	logic               gv_q;
	logic               gv_d;
	logic               gc_q;
	logic               gc_d;
	logic [RW-1:0]      rpf_q;

	logic [FW-1:0]      fv;
	logic               up;
	logic [FW-1:0]      floor_gap;
	logic [FW+RW-1:0]   prod;
	logic               tag_hit;
	logic               two;

	assign advance = valid_s1 && space_ok;
	assign cmd_ready = !valid_s1 || space_ok;
	assign push.valid = advance;
	assign push.two = two;

	assign fv = item_s1.floor_value[FW-1:0];
	assign up = fv > floor_q;
	assign floor_gap = up ? (fv - floor_q) : (floor_q - fv);
	assign prod = floor_gap * rpf_q;
	assign tag_hit = (mode_q == fmc_pkg::MODE_MOVING) && gv_q && (goal_q == fv);

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

	always_comb begin
		mode_d = mode_q;
		floor_d = floor_q;
		goal_d = goal_q;
		gv_d = gv_q;
		gc_d = gc_q;
		unique case (item_s1.op)
			fmc_pkg::OP_REQUEST: begin
				if (mode_q != fmc_pkg::MODE_MOVING) begin
					if (fv == floor_q) begin
						mode_d = fmc_pkg::MODE_ARRIVED;
					end else begin
						mode_d = fmc_pkg::MODE_MOVING;
						goal_d = fv;
						gv_d = 1'b1;
						gc_d = 1'b0;
					end
				end
			end
			fmc_pkg::OP_MOTOR: begin
				if (mode_q == fmc_pkg::MODE_MOVING) begin
					if (item_s1.motor_outcome == fmc_pkg::OUTC_DONE || gc_q) begin
						floor_d = goal_q;
						gv_d = 1'b0;
						mode_d = fmc_pkg::MODE_ARRIVED;
					end else if (item_s1.motor_outcome == fmc_pkg::OUTC_CANCEL) begin
						mode_d = fmc_pkg::MODE_STOPPED;
					end else begin
						mode_d = fmc_pkg::MODE_FAULT;
					end
				end
			end
			fmc_pkg::OP_TAG: begin
				if (tag_hit) begin
					gc_d = 1'b1;
				end
			end
			fmc_pkg::OP_NONE: begin
			end
		endcase
	end

	always_comb begin
		res0 = '0;
		res1 = '0;
		two = 1'b0;
		res0.floor_now = 8'(floor_d);
		res1.floor_now = 8'(floor_d);
		res0.status_state = mode_q;
		res0.status_reason = fmc_pkg::RS_NO_CHANGE;
		res0.last_result = 1'b1;
		res1.last_result = 1'b1;
		unique case (item_s1.op)
			fmc_pkg::OP_REQUEST: begin
				if (mode_q == fmc_pkg::MODE_MOVING) begin
					res0.status_reason = fmc_pkg::RS_REJECTED;
				end else begin
					two = 1'b1;
					res0.status_state = fmc_pkg::MODE_PROCESSING;
					res0.status_reason = fmc_pkg::RS_PROCESSING;
					res0.last_result = 1'b0;
					if (fv == floor_q) begin
						res1.status_state = fmc_pkg::MODE_ARRIVED;
						res1.status_reason = fmc_pkg::RS_ALREADY;
					end else begin
						res1.status_state = fmc_pkg::MODE_MOVING;
						res1.status_reason = fmc_pkg::RS_SUBMITTED;
						res1.move_valid = 1'b1;
						res1.move_direction = !up;
						res1.move_rotations = 24'(prod);
					end
				end
			end
			fmc_pkg::OP_MOTOR: begin
				if (mode_q == fmc_pkg::MODE_MOVING) begin
					res0.status_state = mode_d;
					if (item_s1.motor_outcome == fmc_pkg::OUTC_DONE) begin
						res0.status_reason = fmc_pkg::RS_COMPLETED;
					end else if (gc_q) begin
						res0.status_reason = fmc_pkg::RS_TAG;
					end else if (item_s1.motor_outcome == fmc_pkg::OUTC_CANCEL) begin
						res0.status_reason = fmc_pkg::RS_INTERRUPTED;
					end else begin
						res0.status_reason = fmc_pkg::RS_MOTOR_ERROR;
						res0.fault_code = item_s1.motor_error_code;
					end
				end
			end
			fmc_pkg::OP_TAG: begin
				if (tag_hit) begin
					res0.status_reason = fmc_pkg::RS_TAG;
					res0.stop_request = 1'b1;
				end
			end
			fmc_pkg::OP_NONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= fmc_pkg::MODE_IDLE;
			floor_q <= FW'(1);
			goal_q <= '0;
			gv_q <= 1'b0;
			gc_q <= 1'b0;
			rpf_q <= RW'(1);
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				mode_q <= mode_d;
				floor_q <= floor_d;
				goal_q <= goal_d;
				gv_q <= gv_d;
				gc_q <= gc_d;
			end
			if (cfg_we) begin
				rpf_q <= cfg_wdata[RW-1:0];
			end
		end
	end

endmodule

FILE: rtl/floor_move_controller.sv
// Top level of the floor move controller.
//
//   channel  direction  handshake                payload
//   cmd      in         cmd_valid / cmd_ready    cmd (request, motor result, tag)
//   status   out        status_valid / status_ready  status (one result item)
//   cfg      in         cfg_we                   cfg_wdata (rotations per floor)
//
// An item is registered in the input register on acceptance; its results are written
// into the result queue once there is room for two. A floor request to a lift that
// is not moving yields two results, all other items one; the output side delivers
// one result per cycle while status_ready is high, which bounds the sustained rate.
// The input register holds its item while the queue lacks room for two results.
// Reset leaves the lift idle at floor one with one rotation per floor.
module floor_move_controller #(
	parameter int FLOOR_BITS = fmc_pkg::FLOOR_BITS_DEF,
	parameter int ROTATION_BITS = fmc_pkg::ROTATION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  fmc_pkg::cmd_item_t    cmd,
	output logic                  status_valid,
	input  logic                  status_ready,
	output fmc_pkg::status_item_t status,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata
);

	fmc_pkg::push_t        push;
	fmc_pkg::status_item_t res0;
	fmc_pkg::status_item_t res1;
	logic                  space_ok;

	fmc_core #(
		.FLOOR_BITS(FLOOR_BITS),
		.ROTATION_BITS(ROTATION_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.space_ok(space_ok),
		.push(push),
		.res0(res0),
		.res1(res1)
	);

	fmc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.res0(res0),
		.res1(res1),
		.space_ok(space_ok),
		.status_valid(status_valid),
		.status_ready(status_ready),
		.status(status)
	);

endmodule

FILE: rtl/fmc_checker.sv
// Port checker for the floor move controller and its bind statement.
module fmc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  status_valid,
	input logic                  status_ready,
	input fmc_pkg::status_item_t status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid && $stable(status))
		else $error("Result item changed or dropped while stalled.");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status_ready && !status.last_result |=> status_valid &&
		(status.status_state == fmc_pkg::MODE_ARRIVED ||
		status.status_state == fmc_pkg::MODE_MOVING))
		else $error("First result of a request was not followed by its second.");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status.move_valid |->
		status.status_state == fmc_pkg::MODE_MOVING && status.last_result &&
		status.status_reason == fmc_pkg::RS_SUBMITTED)
		else $error("Move command outside a submitted move.");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status.fault_code != 8'd0 |->
		status.status_state == fmc_pkg::MODE_FAULT)
		else $error("Fault code on a result that is not a fault.");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status.stop_request |->
		status.status_state == fmc_pkg::MODE_MOVING &&
		status.status_reason == fmc_pkg::RS_TAG)
		else $error("Stop request without a confirming tag.");

endmodule

bind floor_move_controller fmc_checker u_fmc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.status_valid(status_valid),
	.status_ready(status_ready),
	.status(status)
);

FILE: tb/floor_move_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the floor move controller: directed, rotation extremes, backpressure and random moves.
module floor_move_controller_tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	fmc_pkg::cmd_item_t cmd_item = '0;
	logic status_valid;
	logic status_ready = 1'b0;
	fmc_pkg::status_item_t status_item;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	fmc_pkg::mode_t lift_mode = fmc_pkg::MODE_IDLE;
	logic [7:0] lift_floor = 8'd1;
	logic [7:0] goal_floor = 8'd0;
	logic goal_set = 1'b0;
	logic goal_seen = 1'b0;
	logic [15:0] rot_per_floor = 16'd1;

	fmc_pkg::status_item_t expected_status[$];
	int err_count = 0;
	int unsigned cycle_count = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_gap = 0;
	int rx_stall_cycles = 0;

	floor_move_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd_item),
		.status_valid(status_valid),
		.status_ready(status_ready),
		.status(status_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(13, 30);
	endfunction

	function automatic fmc_pkg::status_item_t make_status(input fmc_pkg::mode_t st,
			input fmc_pkg::reason_t rs);
		fmc_pkg::status_item_t s;
		s = '0;
		s.status_state = st;
		s.status_reason = rs;
		s.floor_now = lift_floor;
		s.last_result = 1'b1;
		return s;
	endfunction

	function automatic fmc_pkg::cmd_item_t make_cmd(input fmc_pkg::op_t op,
			input logic [7:0] fv, input fmc_pkg::outcome_t oc, input logic [7:0] code);
		fmc_pkg::cmd_item_t c;
		c.op = op;
		c.floor_value = fv;
		c.motor_outcome = oc;
		c.motor_error_code = code;
		return c;
	endfunction

	// Updates the lift state for one accepted item and queues the status items it causes.
	function automatic void predict_status(input fmc_pkg::cmd_item_t c);
		fmc_pkg::status_item_t s;
		logic [7:0] span;
		case (c.op)
			fmc_pkg::OP_REQUEST: begin
				if (lift_mode == fmc_pkg::MODE_MOVING) begin
					expected_status.push_back(make_status(fmc_pkg::MODE_MOVING,
						fmc_pkg::RS_REJECTED));
				end else begin
					lift_mode = fmc_pkg::MODE_PROCESSING;
					s = make_status(fmc_pkg::MODE_PROCESSING, fmc_pkg::RS_PROCESSING);
					s.last_result = 1'b0;
					expected_status.push_back(s);
					if (c.floor_value == lift_floor) begin
						lift_mode = fmc_pkg::MODE_ARRIVED;
						expected_status.push_back(make_status(fmc_pkg::MODE_ARRIVED,
							fmc_pkg::RS_ALREADY));
					end else begin
						s = make_status(fmc_pkg::MODE_MOVING, fmc_pkg::RS_SUBMITTED);
						s.move_valid = 1'b1;
						if (c.floor_value > lift_floor) begin
							span = c.floor_value - lift_floor;
							s.move_direction = 1'b0;
						end else begin
							span = lift_floor - c.floor_value;
							s.move_direction = 1'b1;
						end
						s.move_rotations = 24'(span) * 24'(rot_per_floor);
						goal_floor = c.floor_value;
						goal_set = 1'b1;
						goal_seen = 1'b0;
						lift_mode = fmc_pkg::MODE_MOVING;
						expected_status.push_back(s);
					end
				end
			end
			fmc_pkg::OP_MOTOR: begin
				if (lift_mode != fmc_pkg::MODE_MOVING) begin
					expected_status.push_back(make_status(lift_mode, fmc_pkg::RS_NO_CHANGE));
				end else if (c.motor_outcome == fmc_pkg::OUTC_DONE || goal_seen) begin
					lift_floor = goal_floor;
					goal_set = 1'b0;
					lift_mode = fmc_pkg::MODE_ARRIVED;
					expected_status.push_back(make_status(fmc_pkg::MODE_ARRIVED,
						(c.motor_outcome == fmc_pkg::OUTC_DONE) ?
						fmc_pkg::RS_COMPLETED : fmc_pkg::RS_TAG));
				end else if (c.motor_outcome == fmc_pkg::OUTC_CANCEL) begin
					lift_mode = fmc_pkg::MODE_STOPPED;
					expected_status.push_back(make_status(fmc_pkg::MODE_STOPPED,
						fmc_pkg::RS_INTERRUPTED));
				end else begin
					lift_mode = fmc_pkg::MODE_FAULT;
					s = make_status(fmc_pkg::MODE_FAULT, fmc_pkg::RS_MOTOR_ERROR);
					s.fault_code = c.motor_error_code;
					expected_status.push_back(s);
				end
			end
			default: begin
				if (c.op == fmc_pkg::OP_TAG && lift_mode == fmc_pkg::MODE_MOVING &&
						goal_set && goal_floor == c.floor_value) begin
					goal_seen = 1'b1;
					s = make_status(fmc_pkg::MODE_MOVING, fmc_pkg::RS_TAG);
					s.stop_request = 1'b1;
					expected_status.push_back(s);
				end else begin
					expected_status.push_back(make_status(lift_mode, fmc_pkg::RS_NO_CHANGE));
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t ns: status.%s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : status_check
		fmc_pkg::status_item_t want;
		if (arst_n && status_valid && status_ready) begin
			if (expected_status.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t ns: status item expected none actual %h", $time, status_item);
			end else begin
				want = expected_status.pop_front();
				check_field("status_state", 32'(want.status_state),
					32'(status_item.status_state));
				check_field("status_reason", 32'(want.status_reason),
					32'(status_item.status_reason));
				check_field("floor_now", 32'(want.floor_now), 32'(status_item.floor_now));
				check_field("move_valid", 32'(want.move_valid), 32'(status_item.move_valid));
				check_field("move_direction", 32'(want.move_direction),
					32'(status_item.move_direction));
				check_field("move_rotations", 32'(want.move_rotations),
					32'(status_item.move_rotations));
				check_field("stop_request", 32'(want.stop_request),
					32'(status_item.stop_request));
				check_field("fault_code", 32'(want.fault_code), 32'(status_item.fault_code));
				check_field("last_result", 32'(want.last_result),
					32'(status_item.last_result));
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				rx_steady = !rx_steady;
			if (rx_stall_cycles > 0) begin
				status_ready <= 1'b0;
				rx_stall_cycles--;
			end else if (rx_gap > 0) begin
				status_ready <= 1'b0;
				rx_gap--;
			end else begin
				status_ready <= 1'b1;
				rx_gap = pick_gap(rx_steady);
			end
		end
	end

	task automatic send_cmd(input fmc_pkg::cmd_item_t c);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		predict_status(c);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rotations(input logic [15:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		rot_per_floor = value;
	endtask

	task automatic test_directed();
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_TAG, 8'h01, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_NONE, 8'hFF, fmc_pkg::OUTC_SPARE, 8'hFF));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h01, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'hFF, fmc_pkg::OUTC_SPARE, 8'hFF));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h10, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_TAG, 8'h7F, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_TAG, 8'hFF, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_ERROR, 8'hFF));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_CANCEL, 8'h33));
		send_cmd(make_cmd(fmc_pkg::OP_TAG, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'hFF, fmc_pkg::OUTC_ERROR, 8'hA5));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_SPARE, 8'h5A));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h07, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h07, fmc_pkg::OUTC_DONE, 8'h00));
		send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_CANCEL, 8'h00));
		wait_drained();
	endtask

	task automatic test_rotation_extremes();
		logic [15:0] settings[4];
		settings[0] = 16'd0;
		settings[1] = 16'hFFFF;
		settings[2] = 16'($urandom_range(2, 65534));
		settings[3] = 16'd1;
		foreach (settings[i]) begin
			write_rotations(settings[i]);
			send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
			send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
			send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'hFF, fmc_pkg::OUTC_DONE, 8'h00));
			send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'h00, fmc_pkg::OUTC_DONE, 8'h00));
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		rx_stall_cycles = 150;
		tx_steady = 1'b1;
		repeat (20) begin
			send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'($urandom),
				fmc_pkg::outcome_t'($urandom_range(0, 3)), 8'($urandom)));
			send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'($urandom), fmc_pkg::OUTC_DONE,
				8'($urandom)));
		end
		tx_steady = 1'b0;
		wait_drained();
	endtask

	function automatic logic [7:0] pick_floor();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return lift_floor;
		if (r < 4)
			return lift_floor + 8'($urandom_range(1, 3));
		if (r < 6)
			return lift_floor - 8'($urandom_range(1, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic fmc_pkg::outcome_t pick_outcome();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return fmc_pkg::OUTC_DONE;
		if (r < 6)
			return fmc_pkg::OUTC_CANCEL;
		if (r < 9)
			return fmc_pkg::OUTC_ERROR;
		return fmc_pkg::OUTC_SPARE;
	endfunction

	task automatic test_random_moves(input int item_count);
		int sent;
		int n_tags;
		int k;
		logic [7:0] target;
		sent = 0;
		while (sent < item_count) begin
			if ($urandom_range(0, 29) == 0)
				tx_steady = !tx_steady;
			if ($urandom_range(0, 4) != 0) begin
				target = pick_floor();
				send_cmd(make_cmd(fmc_pkg::OP_REQUEST, target,
					fmc_pkg::outcome_t'($urandom_range(0, 3)), 8'($urandom)));
				n_tags = $urandom_range(0, 3);
				repeat (n_tags) begin
					k = $urandom_range(0, 5);
					if (k < 3)
						send_cmd(make_cmd(fmc_pkg::OP_TAG, target, pick_outcome(),
							8'($urandom)));
					else if (k < 5)
						send_cmd(make_cmd(fmc_pkg::OP_TAG, 8'($urandom), pick_outcome(),
							8'($urandom)));
					else
						send_cmd(make_cmd(fmc_pkg::OP_REQUEST, 8'($urandom), pick_outcome(),
							8'($urandom)));
				end
				send_cmd(make_cmd(fmc_pkg::OP_MOTOR, 8'($urandom), pick_outcome(),
					8'($urandom)));
				sent += 2 + n_tags;
			end else begin
				send_cmd(make_cmd(fmc_pkg::op_t'($urandom_range(0, 3)), 8'($urandom),
					fmc_pkg::outcome_t'($urandom_range(0, 3)), 8'($urandom)));
				sent++;
			end
		end
		tx_steady = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_rotation_extremes();
		test_backpressure();
		write_rotations(16'($urandom_range(2, 40)));
		test_random_moves(400);
		write_rotations(16'hFFFF);
		test_random_moves(390);
		write_rotations(16'd0);
		test_random_moves(390);
		write_rotations(16'($urandom));
		test_random_moves(390);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/fmc_pkg.sv
rtl/fmc_queue.sv
rtl/fmc_core.sv
rtl/floor_move_controller.sv
rtl/fmc_checker.sv
tb/floor_move_controller_tb.sv
